// ----- rtl/binary_to_decimal_ascii_assert.svh -----
// assertion macros for the binary to decimal ascii converter
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked while out of reset
`define BDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked while out of reset
`define BDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BDA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BDA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/bda_pkg.sv -----
// types, constants and helper functions for the binary to decimal ascii converter
`default_nettype none

package bda_pkg;

    localparam int VALUE_W  = 32;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int STEP_W   = $clog2(VALUE_W);
    localparam int IDX_W    = 4;
    localparam int CHAR_W   = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_COUNT,
        S_EMIT
    } t_state;

    // one shift-add-3 step: fix up every digit, then shift in the next binary bit
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic             bin_bit);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bin_bit};
    endfunction

    // number of significant digits, at least one so that zero prints as '0'
    function automatic logic [IDX_W-1:0] digit_len(input logic [BCD_W-1:0] bcd);
        logic [IDX_W-1:0] len;
        len = IDX_W'(1);
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                len = IDX_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/binary_to_decimal_ascii.sv -----
// Unsigned 32-bit binary to decimal ASCII converter. Each accepted word is turned
// into its decimal digits by a shift-add-3 unit that takes one binary bit per
// cycle; a count state then finds the number of significant digits, and then the
// digits leave most significant first, one word per cycle while the downstream
// side is ready. Leading zeros are dropped, zero gives a single '0', every output
// word carries the digit count, and o_last marks the final digit. o_ready is low
// from the accepting edge until the last digit has been taken.
`default_nettype none

`include "binary_to_decimal_ascii_assert.svh"

module binary_to_decimal_ascii (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [bda_pkg::VALUE_W-1:0]       i_value,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic      [bda_pkg::CHAR_W-1:0]        o_digit_char,
    output logic      [bda_pkg::IDX_W-1:0]         o_digit_count,
    output logic                                   o_last
);

    bda_pkg::t_state                     r_state, n_state;
    logic [bda_pkg::VALUE_W-1:0]         r_bin,   n_bin;
    logic [bda_pkg::BCD_W-1:0]           r_bcd,   n_bcd;
    logic [bda_pkg::STEP_W-1:0]          r_step,  n_step;
    logic [bda_pkg::IDX_W-1:0]           r_count, n_count;
    logic [bda_pkg::IDX_W-1:0]           r_idx,   n_idx;

    logic                                in_fire;
    logic                                out_fire;
    logic                                conv_done;
    logic [3:0]                          cur_digit;

    assign in_fire   = i_valid && o_ready;
    assign out_fire  = o_valid && i_ready;
    assign conv_done = (r_step == bda_pkg::STEP_W'(bda_pkg::VALUE_W - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bda_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = bda_pkg::S_CONV;
                end
            end
            bda_pkg::S_CONV: begin
                if (conv_done) begin
                    n_state = bda_pkg::S_COUNT;
                end
            end
            bda_pkg::S_COUNT: begin
                n_state = bda_pkg::S_EMIT;
            end
            bda_pkg::S_EMIT: begin
                if (out_fire && (r_idx == '0)) begin
                    n_state = bda_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bda_pkg::S_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            bda_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            bda_pkg::S_EMIT: begin
                o_valid = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_step  = r_step;
        n_count = r_count;
        n_idx   = r_idx;
        case (r_state)
            bda_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_bin  = i_value;
                    n_bcd  = '0;
                    n_step = '0;
                end
            end
            bda_pkg::S_CONV: begin
                n_bcd  = bda_pkg::dabble_step(r_bcd, r_bin[bda_pkg::VALUE_W-1]);
                n_bin  = {r_bin[bda_pkg::VALUE_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
            end
            bda_pkg::S_COUNT: begin
                n_count = bda_pkg::digit_len(r_bcd);
                n_idx   = bda_pkg::digit_len(r_bcd) - 1'b1;
            end
            bda_pkg::S_EMIT: begin
                if (out_fire && (r_idx != '0)) begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // digit select by position
    always_comb begin
        cur_digit = 4'd0;
        for (int i = 0; i < bda_pkg::DIGITS; i++) begin
            if (r_idx == bda_pkg::IDX_W'(i)) begin
                cur_digit = r_bcd[i*4 +: 4];
            end
        end
    end

    assign o_digit_char  = bda_pkg::ASCII_ZERO | {2'b00, cur_digit};
    assign o_digit_count = r_count;
    assign o_last        = (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bda_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_step  <= n_step;
        r_count <= n_count;
        r_idx   <= n_idx;
    end

    `BDA_ASSERT_IMP(a_busy_while_emit, i_clk, i_rst_n, o_valid, !o_ready)
    `BDA_ASSERT_NXT(a_accept_starts_conv, i_clk, i_rst_n, in_fire, !o_valid && !o_ready)
    `BDA_ASSERT_NXT(a_last_ends_run, i_clk, i_rst_n, out_fire && o_last, !o_valid && o_ready)
    `BDA_ASSERT_IMP(a_char_is_digit, i_clk, i_rst_n, o_valid,
        (o_digit_char >= 6'd48) && (o_digit_char <= 6'd57) && (r_idx < o_digit_count))

endmodule

`default_nettype wire
